>>> rtl/core/egss_pkg.sv
package egss_pkg;

    localparam int unsigned FieldAddrW = 12;
    localparam int unsigned KindW      = 2;
    localparam int unsigned CountW     = 6;
    localparam int unsigned OpCountW   = 13;
    localparam int unsigned RoundW     = 42;
    localparam int unsigned CfgIdxW    = 2;
    localparam int unsigned CfgDataW   = 13;
    localparam int unsigned PiLimit    = 48;

    typedef enum logic [KindW-1:0] {
        GATE_AND = 2'd0,
        GATE_XOR = 2'd1,
        GATE_NOT = 2'd2
    } t_gate_kind;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_INPUT_COUNT = 2'd0,
        CFG_OP_COUNT    = 2'd1,
        CFG_OUTPUT_ADDR = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [KindW-1:0]      kind;
        logic [FieldAddrW-1:0] dest;
        logic [FieldAddrW-1:0] src_a;
        logic [FieldAddrW-1:0] src_b;
    } t_gate;

endpackage

>>> rtl/core/egss_req_if.sv
interface egss_req_if;
    logic                                valid;
    logic                                ready;
    logic                                mode;
    logic [egss_pkg::FieldAddrW-1:0]     op_slot;
    logic [egss_pkg::KindW-1:0]          gate_kind;
    logic [egss_pkg::FieldAddrW-1:0]     dest_addr;
    logic [egss_pkg::FieldAddrW-1:0]     src_a_addr;
    logic [egss_pkg::FieldAddrW-1:0]     src_b_addr;

    modport source (output valid, mode, op_slot, gate_kind, dest_addr, src_a_addr,
                    src_b_addr, input ready);
    modport sink (input valid, mode, op_slot, gate_kind, dest_addr, src_a_addr,
                  src_b_addr, output ready);
endinterface

>>> rtl/core/egss_rsp_if.sv
interface egss_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          found;
    logic [egss_pkg::RoundW-1:0]   found_round;

    modport source (output valid, found, found_round, input ready);
    modport sink (input valid, found, found_round, output ready);
endinterface

>>> rtl/core/exhaustive_gate_simulation_search_unit.sv
// Load request: accepted while idle, one per cycle back to back while no search runs.
// Search request: clears every signal store word, then per round writes the two
// constant words and min(input_count, 48) input words, steps each gate through fetch,
// operand read and write, and checks the output word (check, test); then the result is presented.
// Reset (i_rst_n low, synchronous): configuration to defaults, sequencer idle,
// no result pending. The program store keeps its contents.
module exhaustive_gate_simulation_search_unit #(
    parameter int unsigned LANE_BITS = 6,
    parameter int unsigned MAX_OPS   = 4096,
    parameter int unsigned MEM_WORDS = 4096
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [egss_pkg::CfgIdxW-1:0]   i_cfg_idx,
    input  logic [egss_pkg::CfgDataW-1:0]  i_cfg_data,
    egss_req_if.sink                       i_req,
    egss_rsp_if.source                     o_rsp
);
    localparam int unsigned W    = 2 ** LANE_BITS;
    localparam int unsigned PAW  = $clog2(MAX_OPS);
    localparam int unsigned SAW  = $clog2(MEM_WORDS);
    localparam int unsigned OCW  = $clog2(MAX_OPS + 1);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_CLEAR = 9'b000000010,
        S_INIT  = 9'b000000100,
        S_FETCH = 9'b000001000,
        S_READ  = 9'b000010000,
        S_EXEC  = 9'b000100000,
        S_CHECK = 9'b001000000,
        S_TEST  = 9'b010000000,
        S_DONE  = 9'b100000000
    } t_state;

    // Map a 12-bit field address onto the signal store (modulo a power of two).
    function automatic logic [SAW-1:0] sig_addr(input logic [31:0] a);
        return a[SAW-1:0];
    endfunction

    // Truth-table projection: lane j carries bit p of j.
    function automatic logic [W-1:0] projection(input logic [egss_pkg::CountW-1:0] p);
        logic [W-1:0] w;
        w = '0;
        for (int j = 0; j < W; j++) begin
            w[j] = ((j >> p) & 1) != 0;
        end
        return w;
    endfunction

    // Memories
    egss_pkg::t_gate r_prog [MAX_OPS];
    logic [W-1:0]    r_sig  [MEM_WORDS];

    // Configuration
    logic [egss_pkg::CountW-1:0]   r_input_count;
    logic [egss_pkg::OpCountW-1:0] r_op_count;
    logic [egss_pkg::FieldAddrW-1:0] r_output_addr;

    // Sequencer
    t_state                          r_state, n_state;
    logic [egss_pkg::CountW-1:0]     r_pis, r_lane_pis, r_init_idx;
    logic [OCW-1:0]                  r_ops, r_op_idx;
    logic [egss_pkg::RoundW-1:0]     r_round, r_round_max;
    logic [SAW-1:0]                  r_clr_idx;
    logic [SAW-1:0]                  r_out_addr;
    egss_pkg::t_gate                 r_gate;
    logic [W-1:0]                    r_rd_a, r_rd_b;
    logic                            r_found;

    // Output register
    logic                            r_rsp_valid;
    logic                            r_rsp_found;
    logic [egss_pkg::RoundW-1:0]     r_rsp_round;

    // Datapath helpers
    logic                            req_acc;
    logic [egss_pkg::CountW-1:0]     pis_sat, lane_pis_new, p_idx, rnd_bit;
    logic [OCW-1:0]                  ops_sat;
    logic                            sig_we;
    logic [SAW-1:0]                  sig_waddr, sig_raddr_a, sig_raddr_b;
    logic [W-1:0]                    sig_wdata, init_word;
    logic                            rsp_load;

    assign i_req.ready = (r_state == S_IDLE);
    assign req_acc     = i_req.valid && i_req.ready;
    assign rsp_load    = (r_state == S_DONE) && (!r_rsp_valid || o_rsp.ready);

    assign o_rsp.valid       = r_rsp_valid;
    assign o_rsp.found       = r_rsp_found;
    assign o_rsp.found_round = r_rsp_round;

    // Saturate search setup values.
    always_comb begin
        pis_sat = (32'(r_input_count) > egss_pkg::PiLimit) ?
                  egss_pkg::CountW'(egss_pkg::PiLimit) : r_input_count;
        lane_pis_new = (32'(pis_sat) < LANE_BITS) ? pis_sat : egss_pkg::CountW'(LANE_BITS);
        ops_sat = (32'(r_op_count) > MAX_OPS) ? OCW'(MAX_OPS) : OCW'(r_op_count);
    end

    // Value written into a constant or primary-input word during round setup.
    always_comb begin
        p_idx   = r_init_idx - egss_pkg::CountW'(2);
        rnd_bit = p_idx - r_lane_pis;
        if (r_init_idx == '0) begin
            init_word = '0;
        end else if (r_init_idx == egss_pkg::CountW'(1)) begin
            init_word = '1;
        end else if (p_idx < r_lane_pis) begin
            init_word = projection(p_idx);
        end else begin
            init_word = r_round[rnd_bit] ? '1 : '0;
        end
    end

    // Signal store port control.
    always_comb begin
        sig_we      = 1'b0;
        sig_waddr   = r_clr_idx;
        sig_wdata   = '0;
        sig_raddr_a = sig_addr(32'(r_gate.src_a));
        sig_raddr_b = sig_addr(32'(r_gate.src_b));
        case (r_state)
            S_CLEAR: begin
                sig_we = 1'b1;
            end
            S_INIT: begin
                sig_we    = 1'b1;
                sig_waddr = sig_addr(32'(r_init_idx));
                sig_wdata = init_word;
            end
            S_EXEC: begin
                sig_waddr = sig_addr(32'(r_gate.dest));
                case (egss_pkg::t_gate_kind'(r_gate.kind))
                    egss_pkg::GATE_AND: begin
                        sig_we = 1'b1;
                        sig_wdata = r_rd_a & r_rd_b;
                    end
                    egss_pkg::GATE_XOR: begin
                        sig_we = 1'b1;
                        sig_wdata = r_rd_a ^ r_rd_b;
                    end
                    egss_pkg::GATE_NOT: begin
                        sig_we = 1'b1;
                        sig_wdata = ~r_rd_a;
                    end
                    default: begin
                        sig_we = 1'b0;
                    end
                endcase
            end
            S_CHECK: begin
                sig_raddr_a = r_out_addr;
            end
            default: begin
                sig_we = 1'b0;
            end
        endcase
    end

    // Signal store: one write, two registered reads.
    always_ff @(posedge i_clk) begin
        if (sig_we) begin
            r_sig[sig_waddr] <= sig_wdata;
        end
        r_rd_a <= r_sig[sig_raddr_a];
        r_rd_b <= r_sig[sig_raddr_b];
    end

    // Program store: written by load requests, read during fetch.
    always_ff @(posedge i_clk) begin
        if (req_acc && !i_req.mode && (32'(i_req.op_slot) < MAX_OPS)) begin
            r_prog[PAW'(i_req.op_slot)] <= {i_req.gate_kind, i_req.dest_addr,
                                           i_req.src_a_addr, i_req.src_b_addr};
        end
        r_gate <= r_prog[r_op_idx[PAW-1:0]];
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (req_acc && i_req.mode) n_state = S_CLEAR;
            end
            S_CLEAR: begin
                if (r_clr_idx == SAW'(MEM_WORDS - 1)) n_state = S_INIT;
            end
            S_INIT: begin
                if (r_init_idx == r_pis + egss_pkg::CountW'(1)) begin
                    n_state = (r_ops == '0) ? S_CHECK : S_FETCH;
                end
            end
            S_FETCH: n_state = S_READ;
            S_READ:  n_state = S_EXEC;
            S_EXEC: begin
                n_state = (r_op_idx == r_ops - OCW'(1)) ? S_CHECK : S_FETCH;
            end
            S_CHECK: n_state = S_TEST;
            S_TEST: begin
                if ((r_rd_a != '0) || (r_round == r_round_max)) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_INIT;
                end
            end
            S_DONE: begin
                if (rsp_load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_input_count <= egss_pkg::CountW'(1);
            r_op_count    <= '0;
            r_output_addr <= '0;
            r_rsp_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (egss_pkg::t_cfg_idx'(i_cfg_idx))
                    egss_pkg::CFG_INPUT_COUNT:
                        r_input_count <= i_cfg_data[egss_pkg::CountW-1:0];
                    egss_pkg::CFG_OP_COUNT:
                        r_op_count <= i_cfg_data;
                    egss_pkg::CFG_OUTPUT_ADDR:
                        r_output_addr <= i_cfg_data[egss_pkg::FieldAddrW-1:0];
                    default: begin
                    end
                endcase
            end
            if (rsp_load) begin
                r_rsp_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    // Sequencer counters and search context.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                // Latch the search setup.
                r_pis       <= pis_sat;
                r_lane_pis  <= lane_pis_new;
                r_ops       <= ops_sat;
                r_out_addr  <= sig_addr(32'(r_output_addr));
                r_round_max <= egss_pkg::RoundW'((43'(1) << (pis_sat - lane_pis_new)) - 43'(1));
                r_clr_idx   <= '0;
                r_round     <= '0;
                r_init_idx  <= '0;
                r_op_idx    <= '0;
                r_found     <= 1'b0;
            end
            S_CLEAR: begin
                r_clr_idx <= r_clr_idx + SAW'(1);
            end
            S_INIT: begin
                r_init_idx <= r_init_idx + egss_pkg::CountW'(1);
                r_op_idx   <= '0;
            end
            S_EXEC: begin
                r_op_idx <= r_op_idx + OCW'(1);
            end
            S_TEST: begin
                r_init_idx <= '0;
                if (r_rd_a != '0) begin
                    r_found <= 1'b1;
                end else if (r_round != r_round_max) begin
                    r_round <= r_round + egss_pkg::RoundW'(1);
                end
            end
            default: begin
            end
        endcase
        if (rsp_load) begin
            r_rsp_found <= r_found;
            r_rsp_round <= r_found ? r_round : '0;
        end
    end

endmodule
